// ----- rtl/core/camera_control_reply_parser_assert.svh -----
// Assertion macros shared by the reply parser modules.
// Expects clk and rst_n in the scope of each use.
`ifndef CAMERA_CONTROL_REPLY_PARSER_ASSERT_SVH
`define CAMERA_CONTROL_REPLY_PARSER_ASSERT_SVH

// condition holds at every clock edge outside reset
`define CCRP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CCRP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define CCRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ccrp_pkg.sv -----
// Shared types and constants for the camera-control reply parser.
// No dependencies.
`default_nettype none

package ccrp_pkg;

    localparam int MAX_REPLY_BYTES = 64;
    localparam int POS_W = $clog2(MAX_REPLY_BYTES);
    localparam int CMP_W = (POS_W + 1 > 7) ? POS_W + 1 : 7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    localparam logic [7:0] HDR_BCAST = 8'h88;
    localparam logic [7:0] CAM_MASK = 8'h70;
    localparam logic [7:0] TYPE_MASK = 8'hf0;
    localparam logic [7:0] TERM_BYTE = 8'hff;
    localparam logic [7:0] ERR_NOT_EXEC = 8'h41;

    localparam logic [3:0] TYPE_ACK = 4'h4;
    localparam logic [3:0] TYPE_DONE = 4'h5;
    localparam logic [3:0] TYPE_ERROR = 4'h6;

    localparam logic [2:0] K_ACK = 3'd0;
    localparam logic [2:0] K_INQ = 3'd1;
    localparam logic [2:0] K_BCAST = 3'd2;
    localparam logic [2:0] K_ERROR = 3'd3;
    localparam logic [2:0] K_MISMATCH = 3'd4;
    localparam logic [2:0] K_UNKNOWN = 3'd5;
    localparam logic [2:0] K_ACKUNTERM = 3'd6;
    localparam logic [2:0] K_OVERLONG = 3'd7;

    localparam logic [2:0] EC_NOT_EXEC = 3'd6;
    localparam logic [2:0] EC_UNRECOG = 3'd7;

    typedef struct packed {
        logic       op;
        logic [2:0] camera;
        logic [6:0] keep_limit;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] reply_byte;
        logic [5:0] reply_index;
        logic [6:0] reply_length;
        logic [2:0] error_code;
        logic       bad_terminator;
        logic       last;
    } result_t;

    // up to three results caused by one request, packed from res[0]
    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     res;
    } entry_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/camera_control_reply_parser.sv -----
// Camera-control reply parser top level: front classifier, result queue, back drain.
// Takes one request per cycle while the queue has room; each result is registered in the queue first.
// Third reply bytes of ACK, inquiry and broadcast replies give up to three results, sent
// one per cycle from a four-group queue while result_ready is high; every other request
// gives at most one result. The front stalls only when the queue is full. Reset (rst_n
// low, async) disarms the parser, clears all parse state and empties the queue.
`default_nettype none

module camera_control_reply_parser
    import ccrp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    entry_t    push_data;
    entry_t    head;

    ccrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    ccrp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_data),
        .pop     (pop),
        .rd_data (head),
        .status  (q_status)
    );

    ccrp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- rtl/core/ccrp_front.sv -----
// Front end: accepts requests, tracks parse state and classifies replies.
// Depends on ccrp_pkg; pushes result groups into ccrp_queue.
`default_nettype none

module ccrp_front
    import ccrp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    input  wire item_t     item,
    input  wire q_status_t q_status,
    output logic           push,
    output entry_t         push_data
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_GATHER  = 4'b0010,
        PH_BODY    = 4'b0100,
        PH_ERRTERM = 4'b1000
    } phase_t;

    typedef struct packed {
        logic    vld;
        result_t rec;
    } cand_t;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        header_reg, header_next;
    logic [7:0]        type_reg, type_next;
    logic [2:0]        cam_reg, cam_next;
    logic [6:0]        keep_reg, keep_next;
    logic [1:0]        class_reg, class_next;
    logic [7:0]        err_held_reg, err_held_next;

    cand_t [2:0]       cand;
    logic              accept;
    logic [7:0]        b;
    logic [3:0]        rtype;
    logic [1:0]        n;
    logic [CMP_W-1:0]  pos_plus;

    function automatic cand_t emit_rec(input logic [1:0] cls, input logic [7:0] data,
                                       input logic [POS_W-1:0] pos, input logic term,
                                       input logic [6:0] keep);
        cand_t            c;
        logic [CMP_W-1:0] pw;
        logic [CMP_W-1:0] p1;
        logic [CMP_W-1:0] kp;
        pw = CMP_W'(pos);
        p1 = pw + CMP_W'(1);
        kp = CMP_W'(keep);
        c = '0;
        c.rec.kind = {1'b0, cls};
        if (pw < kp)
        begin
            c.vld = 1'b1;
            c.rec.reply_byte = data;
            c.rec.reply_index = 6'(pos);
            c.rec.reply_length = term ? 7'((p1 < kp) ? p1 : kp) : 7'd0;
            c.rec.last = term;
        end
        else if (term)
        begin
            // terminator past the keep limit: closing result only
            c.vld = 1'b1;
            c.rec.reply_length = keep;
            c.rec.last = 1'b1;
        end
        return c;
    endfunction

    function automatic cand_t fail_rec(input logic [2:0] kind);
        cand_t c;
        c = '0;
        c.vld = 1'b1;
        c.rec.kind = kind;
        c.rec.last = 1'b1;
        return c;
    endfunction

    assign item_ready = !q_status.full;
    assign accept = item_valid && item_ready;
    assign b = item.rx_byte;
    assign rtype = 4'((type_reg & TYPE_MASK) >> 4);
    assign pos_plus = CMP_W'(pos_reg) + CMP_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        header_next = header_reg;
        type_next = type_reg;
        cam_next = cam_reg;
        keep_next = keep_reg;
        class_next = class_reg;
        err_held_next = err_held_reg;
        cand = '0;
        if (accept)
        begin
            if (item.op == OP_START)
            begin
                cam_next = item.camera;
                keep_next = item.keep_limit;
                pos_next = '0;
                header_next = '0;
                type_next = '0;
                class_next = '0;
                err_held_next = '0;
                phase_next = PH_GATHER;
            end
            else
            begin
                case (phase_reg)
                    PH_GATHER:
                    begin
                        if (pos_reg == POS_W'(0))
                        begin
                            header_next = b;
                            pos_next = POS_W'(1);
                        end
                        else if (pos_reg == POS_W'(1))
                        begin
                            type_next = b;
                            pos_next = POS_W'(2);
                        end
                        else if (header_reg != HDR_BCAST &&
                                 3'((header_reg & CAM_MASK) >> 4) != cam_reg)
                        begin
                            cand[0] = fail_rec(K_MISMATCH);
                            phase_next = PH_IDLE;
                        end
                        else if (header_reg != HDR_BCAST && rtype == TYPE_ACK)
                        begin
                            if (b != TERM_BYTE)
                            begin
                                cand[0] = fail_rec(K_ACKUNTERM);
                            end
                            else
                            begin
                                class_next = K_ACK[1:0];
                                cand[0] = emit_rec(K_ACK[1:0], header_reg, POS_W'(0), 1'b0,
                                                   keep_reg);
                                cand[1] = emit_rec(K_ACK[1:0], type_reg, POS_W'(1), 1'b0,
                                                   keep_reg);
                                cand[2] = emit_rec(K_ACK[1:0], b, POS_W'(2), 1'b1, keep_reg);
                            end
                            phase_next = PH_IDLE;
                        end
                        else if (header_reg != HDR_BCAST && rtype == TYPE_DONE &&
                                 b == TERM_BYTE)
                        begin
                            // completion: drop and gather the next reply
                            pos_next = '0;
                        end
                        else if (header_reg != HDR_BCAST && rtype == TYPE_ERROR)
                        begin
                            err_held_next = b;
                            phase_next = PH_ERRTERM;
                        end
                        else if (header_reg != HDR_BCAST && rtype != TYPE_DONE)
                        begin
                            cand[0] = fail_rec(K_UNKNOWN);
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            class_next = (header_reg == HDR_BCAST) ? K_BCAST[1:0] : K_INQ[1:0];
                            cand[0] = emit_rec(class_next, header_reg, POS_W'(0), 1'b0,
                                               keep_reg);
                            cand[1] = emit_rec(class_next, type_reg, POS_W'(1), 1'b0,
                                               keep_reg);
                            cand[2] = emit_rec(class_next, b, POS_W'(2), 1'b0, keep_reg);
                            phase_next = PH_BODY;
                            pos_next = POS_W'(3);
                        end
                    end
                    PH_ERRTERM:
                    begin
                        cand[0] = fail_rec(K_ERROR);
                        if (err_held_reg inside {[8'd1:8'd5]})
                        begin
                            cand[0].rec.error_code = err_held_reg[2:0];
                        end
                        else if (err_held_reg == ERR_NOT_EXEC)
                        begin
                            cand[0].rec.error_code = EC_NOT_EXEC;
                        end
                        else
                        begin
                            cand[0].rec.error_code = EC_UNRECOG;
                        end
                        cand[0].rec.bad_terminator = (b != TERM_BYTE);
                        phase_next = PH_IDLE;
                    end
                    PH_BODY:
                    begin
                        if (b == TERM_BYTE)
                        begin
                            cand[0] = emit_rec(class_reg, b, pos_reg, 1'b1, keep_reg);
                            phase_next = PH_IDLE;
                        end
                        else if (pos_plus >= CMP_W'(MAX_REPLY_BYTES))
                        begin
                            cand[0] = fail_rec(K_OVERLONG);
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            cand[0] = emit_rec(class_reg, b, pos_reg, 1'b0, keep_reg);
                            pos_next = POS_W'(pos_plus);
                        end
                    end
                    default:
                    begin
                        // not armed: byte dropped
                    end
                endcase
            end
        end
    end

    // pack valid candidates from slot 0
    always_comb
    begin
        push_data = '0;
        n = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            if (cand[i].vld)
            begin
                push_data.res[n] = cand[i].rec;
                n = n + 2'd1;
            end
        end
        push_data.count = n;
    end

    assign push = accept && (n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg <= '0;
            header_reg <= '0;
            type_reg <= '0;
            cam_reg <= '0;
            keep_reg <= '0;
            class_reg <= '0;
            err_held_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            header_reg <= header_next;
            type_reg <= type_next;
            cam_reg <= cam_next;
            keep_reg <= keep_next;
            class_reg <= class_next;
            err_held_reg <= err_held_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ccrp_queue.sv -----
// Short FIFO of result groups between the front and back ends.
// Depends on ccrp_pkg and the assertion macro header.
`default_nettype none

`include "camera_control_reply_parser_assert.svh"

module ccrp_queue
    import ccrp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t wr_data,
    input  wire logic   pop,
    output entry_t      rd_data,
    output q_status_t   status
);

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign status.full = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.valid = (cnt_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    `CCRP_ASSERT_ALWAYS(a_q_bound, cnt_reg <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
    `CCRP_ASSERT_IMPLY(a_q_pop_nonempty, pop, cnt_reg != '0, "pop from empty queue")
    `CCRP_ASSERT_IMPLY(a_q_push_ok, push, !status.full && wr_data.count != 2'd0,
                       "bad push into queue")

endmodule

`default_nettype wire

// ----- rtl/core/ccrp_back.sv -----
// Back end: drains result groups from the queue one result per output handshake.
// Depends on ccrp_pkg and the assertion macro header.
`default_nettype none

`include "camera_control_reply_parser_assert.svh"

module ccrp_back
    import ccrp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire entry_t    head,
    input  wire q_status_t q_status,
    output logic           pop,
    output logic           result_valid,
    input  wire logic      result_ready,
    output result_t        result
);

    logic [1:0] sub_reg, sub_next;
    logic       group_end;

    assign result_valid = q_status.valid;
    assign result = head.res[sub_reg];
    assign group_end = (sub_reg == head.count - 2'd1);
    assign pop = result_valid && result_ready && group_end;

    always_comb
    begin
        sub_next = sub_reg;
        if (result_valid && result_ready)
        begin
            sub_next = group_end ? 2'd0 : sub_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= 2'd0;
        end
        else
        begin
            sub_reg <= sub_next;
        end
    end

    `CCRP_ASSERT_IMPLY(a_b_sub_range, q_status.valid, sub_reg < head.count,
                       "sub index past group")
    `CCRP_ASSERT_NEXT(a_b_sub_hold, result_valid && !result_ready, $stable(sub_reg),
                      "sub index moved while stalled")
    `CCRP_ASSERT_IMPLY(a_b_pop_end, pop, sub_reg == head.count - 2'd1,
                       "group popped before its last result")

endmodule

`default_nettype wire

// ----- test/camera_control_reply_parser_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for camera_control_reply_parser: reply bytes in, results checked.
// Depends on ccrp_pkg and the parser RTL; a behavioral parser below predicts every result.

module camera_control_reply_parser_tb;
    import ccrp_pkg::*;

    typedef enum logic [1:0] {
        PARSE_IDLE,
        PARSE_GATHER,
        PARSE_BODY,
        PARSE_ERR_TERM
    } parse_phase_t;

    localparam logic [7:0] ERR_CODE_LO = 8'd1;
    localparam logic [7:0] ERR_CODE_HI = 8'd5;
    localparam logic [3:0] TYPE_OTHER = 4'h7;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_LIMIT = 10;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    camera_control_reply_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // behavioral copy of the parse state
    parse_phase_t ph = PARSE_IDLE;
    logic [6:0]   byte_pos = '0;
    logic [7:0]   hdr_byte = '0;
    logic [7:0]   type_byte = '0;
    logic [7:0]   err_held = '0;
    logic [2:0]   want_cam = '0;
    logic [2:0]   reply_cls = '0;
    logic [6:0]   keep_count = '0;

    result_t replies_due[$];
    int      fail_count = 0;
    int      live_items = 0;
    int      burst_left = 0;
    bit      steady = 1'b0;
    int      hold_cycles = 0;
    int      rx_cycle = 0;
    int      rx_mode = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic void queue_result(input logic [2:0] kind, input logic [7:0] b,
                                         input logic [5:0] idx, input logic [6:0] len,
                                         input logic [2:0] err, input logic bt,
                                         input logic fin);
        result_t r;
        r.kind = kind;
        r.reply_byte = b;
        r.reply_index = idx;
        r.reply_length = len;
        r.error_code = err;
        r.bad_terminator = bt;
        r.last = fin;
        replies_due.push_back(r);
    endfunction

    function automatic void fail_reply(input logic [2:0] kind);
        ph = PARSE_IDLE;
        queue_result(kind, 8'h00, 6'd0, 7'd0, 3'd0, 1'b0, 1'b1);
    endfunction

    // bytes past the keep limit are dropped; a dropped terminator still closes the reply
    function automatic void emit_reply_byte(input logic [7:0] b, input logic [6:0] pos,
                                            input logic term);
        logic [6:0] len;
        if (pos < keep_count)
        begin
            len = term ? pos + 7'd1 : 7'd0;
            queue_result(reply_cls, b, pos[5:0], len, 3'd0, 1'b0, term);
        end
        else if (term)
        begin
            queue_result(reply_cls, 8'h00, 6'd0, keep_count, 3'd0, 1'b0, 1'b1);
        end
    endfunction

    function automatic void classify_third_byte(input logic [7:0] b);
        logic [3:0] rtype;
        rtype = type_byte[7:4];
        if (hdr_byte != HDR_BCAST && ((hdr_byte & CAM_MASK) >> 4) != want_cam)
        begin
            fail_reply(K_MISMATCH);
            return;
        end
        if (hdr_byte == HDR_BCAST)
        begin
            reply_cls = K_BCAST;
        end
        else if (rtype == TYPE_ACK)
        begin
            if (b != TERM_BYTE)
            begin
                fail_reply(K_ACKUNTERM);
                return;
            end
            reply_cls = K_ACK;
            emit_reply_byte(hdr_byte, 7'd0, 1'b0);
            emit_reply_byte(type_byte, 7'd1, 1'b0);
            emit_reply_byte(b, 7'd2, 1'b1);
            ph = PARSE_IDLE;
            return;
        end
        else if (rtype == TYPE_DONE)
        begin
            // completion: drop it and gather the next reply
            if (b == TERM_BYTE)
            begin
                byte_pos = 7'd0;
                return;
            end
            reply_cls = K_INQ;
        end
        else if (rtype == TYPE_ERROR)
        begin
            err_held = b;
            ph = PARSE_ERR_TERM;
            return;
        end
        else
        begin
            fail_reply(K_UNKNOWN);
            return;
        end
        emit_reply_byte(hdr_byte, 7'd0, 1'b0);
        emit_reply_byte(type_byte, 7'd1, 1'b0);
        emit_reply_byte(b, 7'd2, 1'b0);
        ph = PARSE_BODY;
        byte_pos = 7'd3;
    endfunction

    function automatic void parse_request(input item_t it);
        logic [2:0] code;
        if (it.op == OP_START)
        begin
            want_cam = it.camera;
            keep_count = it.keep_limit;
            byte_pos = '0;
            hdr_byte = '0;
            type_byte = '0;
            reply_cls = '0;
            err_held = '0;
            ph = PARSE_GATHER;
            return;
        end
        case (ph)
            PARSE_GATHER:
            begin
                if (byte_pos == 7'd0)
                begin
                    hdr_byte = it.rx_byte;
                    byte_pos = 7'd1;
                end
                else if (byte_pos == 7'd1)
                begin
                    type_byte = it.rx_byte;
                    byte_pos = 7'd2;
                end
                else
                begin
                    classify_third_byte(it.rx_byte);
                end
            end
            PARSE_ERR_TERM:
            begin
                if (err_held >= ERR_CODE_LO && err_held <= ERR_CODE_HI)
                    code = err_held[2:0];
                else if (err_held == ERR_NOT_EXEC)
                    code = EC_NOT_EXEC;
                else
                    code = EC_UNRECOG;
                ph = PARSE_IDLE;
                queue_result(K_ERROR, 8'h00, 6'd0, 7'd0, code, it.rx_byte != TERM_BYTE, 1'b1);
            end
            PARSE_BODY:
            begin
                if (it.rx_byte == TERM_BYTE)
                begin
                    ph = PARSE_IDLE;
                    emit_reply_byte(it.rx_byte, byte_pos, 1'b1);
                end
                else if (byte_pos + 7'd1 >= MAX_REPLY_BYTES)
                begin
                    fail_reply(K_OVERLONG);
                end
                else
                begin
                    emit_reply_byte(it.rx_byte, byte_pos, 1'b0);
                    byte_pos = byte_pos + 7'd1;
                end
            end
            default: ;
        endcase
    endfunction

    // bursts of random length separated by random gaps; valid stays up inside a burst
    task automatic send_item(input item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        if (it.op == OP_START || ph != PARSE_IDLE)
            live_items++;
        parse_request(it);
    endtask

    task automatic send_start(input logic [2:0] cam, input logic [6:0] keep);
        item_t it;
        it = item_t'($urandom);
        it.op = OP_START;
        it.camera = cam;
        it.keep_limit = keep;
        send_item(it);
    endtask

    task automatic send_rx(input logic [7:0] b);
        item_t it;
        it = item_t'($urandom);
        it.op = OP_BYTE;
        it.rx_byte = b;
        send_item(it);
    endtask

    task automatic wait_for_replies();
        item_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] cam_header(input logic [2:0] cam);
        return {1'b1, cam, 4'h0};
    endfunction

    function automatic logic [6:0] pick_keep();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 7'($urandom_range(0, 6));
        else if (pick < 80)
            return 7'($urandom_range(0, 64));
        else if (pick < 92)
            return 7'd64;
        else
            return 7'($urandom_range(65, 127));
    endfunction

    task automatic test_ack_keep_zero();
        send_start(3'd7, 7'd0);
        send_rx(cam_header(3'd7));
        send_rx({TYPE_ACK, 4'h0});
        send_rx(TERM_BYTE);
    endtask

    task automatic test_completion_inquiry();
        send_start(3'd3, 7'd127);
        send_rx(cam_header(3'd3));
        send_rx({TYPE_DONE, 4'h1});
        send_rx(TERM_BYTE);
        send_rx(cam_header(3'd3));
        send_rx({TYPE_DONE, 4'hf});
        send_rx(8'h12);
        send_rx(TERM_BYTE);
    endtask

    task automatic test_error_reply();
        send_start(3'd3, 7'd64);
        send_rx(cam_header(3'd3));
        send_rx({TYPE_ERROR, 4'h1});
        send_rx(ERR_NOT_EXEC);
        send_rx(8'h00);
        // disarmed now, so this byte is dropped
        send_rx(TERM_BYTE);
    endtask

    task automatic test_broadcast_keep();
        // 0xff as type and third byte must not end the reply
        send_start(3'd0, 7'd2);
        send_rx(HDR_BCAST);
        send_rx(TERM_BYTE);
        send_rx(TERM_BYTE);
        send_rx(TERM_BYTE);
    endtask

    task automatic test_failures();
        // re-arm mid-reply, then a header for the old camera
        send_start(3'd1, 7'd5);
        send_rx(cam_header(3'd1));
        send_rx({TYPE_ACK, 4'h1});
        send_start(3'd2, 7'd5);
        send_rx(cam_header(3'd1));
        send_rx({TYPE_ACK, 4'h1});
        send_rx(TERM_BYTE);
        send_start(3'd2, 7'd5);
        send_rx(cam_header(3'd2));
        send_rx({TYPE_OTHER, 4'h2});
        send_rx(8'h00);
        send_start(3'd2, 7'd5);
        send_rx(cam_header(3'd2));
        send_rx({TYPE_ACK, 4'h1});
        send_rx(8'h00);
    endtask

    task automatic test_long_replies();
        // terminator lands on the last buffer slot, then a reply that runs past it
        send_start(3'd5, 7'd64);
        send_rx(HDR_BCAST);
        send_rx(8'h00);
        send_rx(8'h5a);
        repeat (MAX_REPLY_BYTES - 4) send_rx(8'($urandom_range(0, 254)));
        send_rx(TERM_BYTE);
        send_start(3'd5, 7'd127);
        send_rx(HDR_BCAST);
        send_rx(8'h00);
        send_rx(8'ha5);
        repeat (MAX_REPLY_BYTES - 3) send_rx(8'($urandom_range(0, 254)));
        send_rx(TERM_BYTE);
    endtask

    task automatic send_well_formed_reply();
        logic [2:0] cam;
        logic [2:0] off;
        logic [3:0] rtype;
        logic [3:0] nib;
        logic [7:0] hdr;
        logic [7:0] third;
        logic       hb;
        int         pick;
        int         body_len;
        cam = 3'($urandom_range(0, 7));
        send_start(cam, pick_keep());
        if ($urandom_range(0, 3) == 0)
        begin
            nib = 4'($urandom);
            send_rx(cam_header(cam) | nib);
            nib = 4'($urandom);
            send_rx({TYPE_DONE, nib});
            send_rx(TERM_BYTE);
        end
        hb = 1'($urandom);
        nib = 4'($urandom);
        off = 3'($urandom_range(1, 7));
        pick = $urandom_range(0, 99);
        if (pick < 12)
            hdr = HDR_BCAST;
        else if (pick < 22)
            hdr = {hb, cam + off, nib};
        else
            hdr = {hb, cam, nib};
        pick = $urandom_range(0, 99);
        if (pick < 30)
            rtype = TYPE_ACK;
        else if (pick < 60)
            rtype = TYPE_DONE;
        else if (pick < 80)
            rtype = TYPE_ERROR;
        else
        begin
            rtype = 4'($urandom_range(0, 12));
            if (rtype >= TYPE_ACK)
                rtype = rtype + 4'd3;
        end
        if (hdr == HDR_BCAST)
            third = ($urandom_range(0, 4) == 0) ? TERM_BYTE : 8'($urandom_range(0, 255));
        else if (rtype == TYPE_ACK)
            third = ($urandom_range(0, 99) < 85) ? TERM_BYTE : 8'($urandom_range(0, 254));
        else if (rtype == TYPE_DONE)
            third = 8'($urandom_range(0, 254));
        else if (rtype == TYPE_ERROR)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                third = 8'($urandom_range(0, 7));
            else if (pick < 80)
                third = ERR_NOT_EXEC;
            else
                third = 8'($urandom_range(0, 255));
        end
        else
            third = 8'($urandom_range(0, 255));
        nib = 4'($urandom);
        send_rx(hdr);
        send_rx({rtype, nib});
        send_rx(third);
        if (ph == PARSE_ERR_TERM)
        begin
            send_rx(($urandom_range(0, 4) != 0) ? TERM_BYTE : 8'($urandom_range(0, 255)));
        end
        else if (ph == PARSE_BODY)
        begin
            body_len = ($urandom_range(0, 39) == 0) ? $urandom_range(58, 62)
                                                     : $urandom_range(0, 5);
            repeat (body_len) send_rx(8'($urandom_range(0, 254)));
            if (ph == PARSE_BODY)
                send_rx(TERM_BYTE);
        end
    endtask

    task automatic send_broken_reply();
        logic [2:0] cam;
        cam = 3'($urandom_range(0, 7));
        send_start(cam, pick_keep());
        if ($urandom_range(0, 1) == 0)
            send_rx(cam_header(cam));
        repeat ($urandom_range(0, 4)) send_rx(8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_replies(input int count);
        int    goal;
        int    pick;
        item_t it;
        goal = live_items + count;
        while (live_items < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_well_formed_reply();
            else if (pick < 85)
                send_broken_reply();
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    it = item_t'($urandom);
                    send_item(it);
                end
            end
        end
    endtask

    // receiver held off while requests keep coming, so the result queue fills
    task automatic test_backpressure();
        int goal;
        hold_cycles = 200;
        steady = 1'b1;
        goal = live_items + 20;
        while (live_items < goal)
            send_well_formed_reply();
        steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        wait_for_replies();
    endtask

    // receiver stall pattern, chosen by a randomly re-picked rx_mode
    always @(posedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 40 == 0)
            rx_mode = $urandom_range(0, 3);
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            result_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: result_ready <= 1'b1;
                1: result_ready <= ($urandom_range(0, 99) >= 30);
                2: result_ready <= ($urandom_range(0, 99) >= 75);
                default: result_ready <= (rx_cycle % 3 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (replies_due.size() == 0)
            begin
                if (fail_count < REPORT_LIMIT)
                    $display("%0t: unexpected kind %0d byte %02h idx %0d len %0d last %0b",
                             $time, result.kind, result.reply_byte, result.reply_index,
                             result.reply_length, result.last);
                fail_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (result.kind !== want.kind || result.reply_byte !== want.reply_byte ||
                    result.reply_index !== want.reply_index ||
                    result.reply_length !== want.reply_length ||
                    result.error_code !== want.error_code ||
                    result.bad_terminator !== want.bad_terminator ||
                    result.last !== want.last)
                begin
                    if (fail_count < REPORT_LIMIT)
                    begin
                        $display("%0t: got  k=%0d b=%02h i=%0d len=%0d err=%0d bt=%0b last=%0b",
                                 $time, result.kind, result.reply_byte, result.reply_index,
                                 result.reply_length, result.error_code,
                                 result.bad_terminator, result.last);
                        $display("%0t: want k=%0d b=%02h i=%0d len=%0d err=%0d bt=%0b last=%0b",
                                 $time, want.kind, want.reply_byte, want.reply_index,
                                 want.reply_length, want.error_code,
                                 want.bad_terminator, want.last);
                    end
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_ack_keep_zero();
        test_completion_inquiry();
        test_error_reply();
        test_broadcast_keep();
        test_failures();
        test_long_replies();
        test_random_replies(45);
        test_backpressure();
        test_drain_pause();
        test_random_replies(30);
        wait_for_replies();
        if (fail_count == 0 && replies_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
